// ===== sv/hrht_pkg.sv =====
// Shared types and constants for the HTTP request header tokenizer.
package hrht_pkg;

    // Event codes carried with each result transfer.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_METHOD   = 3'd1,
        EV_URI      = 3'd2,
        EV_VERSION  = 3'd3,
        EV_KEY      = 3'd4,
        EV_VALUE    = 3'd5,
        EV_END      = 3'd6,
        EV_OVERFLOW = 3'd7
    } event_t;

    // One result item as it leaves the parser.
    typedef struct packed {
        event_t      event_res;
        logic [15:0] token_finish;
        logic [15:0] token_begin;
    } result_t;

    // Characters the parser looks for.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // Register map and reset value of the request size limit.
    localparam int unsigned ADDR_BITS          = 3;
    localparam logic [15:0] MAX_BYTES_RESET    = 16'd4096;
    localparam logic        REG_IDX_MAX_BYTES  = 1'b0;

endpackage

// ===== sv/hrht_core.sv =====
// Parse state registers and per-byte tokenizing logic.
module hrht_core
    import hrht_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic [7:0]    data_byte,
    input  logic [15:0]   max_request_bytes,
    output result_t       result
);

    localparam int unsigned CMP_W = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;

    typedef enum logic [3:0] {
        ST_RL_START  = 4'd0,
        ST_METHOD    = 4'd1,
        ST_SP_URI    = 4'd2,
        ST_URI       = 4'd3,
        ST_SP_VER    = 4'd4,
        ST_VER       = 4'd5,
        ST_HDR_START = 4'd6,
        ST_KEY       = 4'd7,
        ST_SP_VALUE  = 4'd8,
        ST_VALUE     = 4'd9
    } state_t;

    state_t                  state_reg,   state_next;
    logic [OFFSET_BITS-1:0]  offset_reg,  offset_next;
    logic [OFFSET_BITS-1:0]  pending_reg, pending_next;
    logic                    err_reg,     err_next;

    logic [OFFSET_BITS-1:0]  ofs_prev;
    logic [OFFSET_BITS-1:0]  ofs_succ;
    logic                    over_limit;
    event_t                  ev;
    logic [OFFSET_BITS-1:0]  tok_b;
    logic [OFFSET_BITS-1:0]  tok_f;
    logic [OFFSET_BITS+15:0] tok_b_ext;
    logic [OFFSET_BITS+15:0] tok_f_ext;

    // Neighbor offsets wrap at the offset width.
    assign ofs_prev   = offset_reg - OFFSET_BITS'(1);
    assign ofs_succ   = offset_reg + OFFSET_BITS'(1);
    assign over_limit = CMP_W'(offset_reg) >= CMP_W'(max_request_bytes);

    // Next state and result for the byte at the input.
    always_comb
    begin
        state_next   = state_reg;
        offset_next  = offset_reg;
        pending_next = pending_reg;
        err_next     = err_reg;
        ev           = EV_NONE;
        tok_b        = '0;
        tok_f        = '0;
        if (err_reg)
        begin
            ev = EV_OVERFLOW;
        end
        else if (over_limit)
        begin
            ev       = EV_OVERFLOW;
            err_next = 1'b1;
        end
        else
        begin
            offset_next = ofs_succ;
            unique case (state_reg)
                ST_METHOD:
                begin
                    if (data_byte == CH_SPACE)
                    begin
                        ev         = EV_METHOD;
                        tok_b      = pending_reg;
                        tok_f      = offset_reg;
                        state_next = ST_SP_URI;
                    end
                end
                ST_SP_URI:
                begin
                    pending_next = offset_reg;
                    state_next   = ST_URI;
                end
                ST_URI:
                begin
                    if (data_byte == CH_SPACE)
                    begin
                        ev         = EV_URI;
                        tok_b      = pending_reg;
                        tok_f      = offset_reg;
                        state_next = ST_SP_VER;
                    end
                end
                ST_SP_VER:
                begin
                    pending_next = offset_reg;
                    state_next   = ST_VER;
                end
                ST_VER:
                begin
                    if (data_byte == CH_LF)
                    begin
                        ev         = EV_VERSION;
                        tok_b      = pending_reg;
                        tok_f      = ofs_prev;
                        state_next = ST_HDR_START;
                    end
                end
                ST_HDR_START:
                begin
                    // A carriage return keeps the line start; a bare line feed ends headers.
                    if (data_byte == CH_LF)
                    begin
                        ev           = EV_END;
                        tok_f        = ofs_succ;
                        state_next   = ST_RL_START;
                        pending_next = '0;
                        offset_next  = '0;
                    end
                    else if (data_byte != CH_CR)
                    begin
                        pending_next = offset_reg;
                        state_next   = ST_KEY;
                    end
                end
                ST_KEY:
                begin
                    if (data_byte == CH_SPACE)
                    begin
                        ev         = EV_KEY;
                        tok_b      = pending_reg;
                        tok_f      = ofs_prev;
                        state_next = ST_SP_VALUE;
                    end
                end
                ST_SP_VALUE:
                begin
                    pending_next = offset_reg;
                    state_next   = ST_VALUE;
                end
                ST_VALUE:
                begin
                    if (data_byte == CH_LF)
                    begin
                        ev         = EV_VALUE;
                        tok_b      = pending_reg;
                        tok_f      = ofs_prev;
                        state_next = ST_HDR_START;
                    end
                end
                default:
                begin
                    // Request line start: any byte opens the method.
                    pending_next = offset_reg;
                    state_next   = ST_METHOD;
                end
            endcase
        end
    end

    // Offsets are reported in their low 16 bits.
    assign tok_b_ext = {16'b0, tok_b};
    assign tok_f_ext = {16'b0, tok_f};

    always_comb
    begin
        result.event_res    = ev;
        result.token_begin  = tok_b_ext[15:0];
        result.token_finish = tok_f_ext[15:0];
    end

    // Parse state advances once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RL_START;
            offset_reg  <= '0;
            pending_reg <= '0;
            err_reg     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            pending_reg <= pending_next;
            err_reg     <= err_next;
        end
    end

    // The error condition is sticky until reset.
    assert property (@(posedge clk) disable iff (!rst_n) err_reg |=> err_reg)
        else $error("error flag cleared without reset");

    // Once in error, the parse position no longer moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> ($stable(offset_reg) && $stable(state_reg)))
        else $error("parse state moved while in error");

    // The end of headers restarts the offset for the next request.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (ev == EV_END)) |=> (offset_reg == '0 && state_reg == ST_RL_START))
        else $error("offset not restarted after end of headers");

endmodule

// ===== sv/http_request_header_tokenizer_top.sv =====
// Top level of the HTTP request header tokenizer: stream ports, register port, result register.
//
//  Channel   Direction  Transfer                      Content
//  s_*       in         one request byte              tdata[7:0] data_byte
//  m_*       out        one result per byte           tuser event_res, tdata begin/finish
//  APB       in/out     register write/read           max_request_bytes at address 0
//
//  Every input byte yields one result in the cycle after its transfer; one byte per cycle
//  is sustained while m_tready is high, limited only by the single result register.
//  The input is taken whenever the result register is empty or being drained in the
//  same cycle, so a stall on m_tready holds s_tready low only while a result waits.
//  Reset clears the parse state, the offsets, the error flag and the result valid,
//  and sets max_request_bytes to 4096. No clearing pass is needed.
module http_request_header_tokenizer_top
    import hrht_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [15:0] token_begin, [31:16] token_finish
    output logic [2:0]           m_tuser,   // [2:0] event_res
    // Register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [15:0] max_bytes_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     step_res;
    logic        in_xfer;
    logic        cfg_wr;

    assign s_tready = !out_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    // Register port: always ready, one register at index zero.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_IDX_MAX_BYTES) ? {16'b0, max_bytes_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_IDX_MAX_BYTES))
        begin
            max_bytes_reg <= pwdata[15:0];
        end
    end

    hrht_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .advance           (in_xfer),
        .data_byte         (s_tdata),
        .max_request_bytes (max_bytes_reg),
        .result            (step_res)
    );

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    // Result payload is loaded on every input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {out_reg.token_finish, out_reg.token_begin};

    // Each accepted byte shows up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> m_tvalid)
        else $error("accepted byte produced no result");

    // No-event and overflow results carry zero offsets.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.event_res == EV_NONE || out_reg.event_res == EV_OVERFLOW))
        |-> (m_tdata == 32'b0))
        else $error("offsets set on a result without a token");

    // A stalled result stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule
